### design/dsnw_pkg.sv
package dsnw_pkg;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 3;
    localparam int SEG_W   = 7;
    localparam int CFG_W   = 3;

    // Register indexes of the configuration port
    localparam logic REG_COMMON_ANODE  = 1'b0;
    localparam logic REG_DIGITS_IN_USE = 1'b1;

    localparam logic [INDEX_W-1:0] DIGITS_RESET = 3'd4;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [VALUE_W-1:0] number_value;
    } in_data_t;

    typedef struct packed {
        logic [INDEX_W-1:0] display_index;
        logic [SEG_W-1:0]   segments;
        logic               write_enable;
        logic               status;
        logic               last;
    } out_data_t;

    typedef struct packed {
        logic             index;
        logic [CFG_W-1:0] value;
    } cfg_data_t;

    // Controller to datapath
    typedef struct packed {
        logic               load;
        logic               step;
        logic               fault;
        logic               first;
        logic               last;
        logic [INDEX_W-1:0] index;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

    // Common-cathode pattern of one decimal digit
    function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'b0111111;
            4'd1:    seg = 7'b0000110;
            4'd2:    seg = 7'b1011011;
            4'd3:    seg = 7'b1001111;
            4'd4:    seg = 7'b1100110;
            4'd5:    seg = 7'b1101101;
            4'd6:    seg = 7'b1111101;
            4'd7:    seg = 7'b0000111;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1101111;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

### design/dsnw_chan_if.sv
interface dsnw_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/dsnw_datapath.sv
module dsnw_datapath
    import dsnw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [VALUE_W-1:0] number_value,
    input  logic               common_anode,
    input  logic               out_ready,
    output logic               out_valid,
    output out_data_t          out_data
);

    logic [VALUE_W-1:0]   rem_reg;
    logic [VALUE_W-1:0]   rem_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_data_t            out_data_reg;
    out_data_t            out_data_next;
    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [3:0]           digit;
    logic                 blank;
    logic [SEG_W-1:0]     invert;
    logic [SEG_W-1:0]     seg;

    // Divide by ten through the reciprocal, remainder by back-multiplication
    assign product  = 32'(rem_reg) * 32'(RECIP_TEN);
    assign quot     = VALUE_W'(product >> RECIP_SHIFT);
    assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
    assign digit    = 4'(rem_reg - quot_x10);

    // Leading positions above the highest digit stay dark
    assign blank  = !cmd.first && (rem_reg == '0);
    assign invert = common_anode ? {SEG_W{1'b1}} : {SEG_W{1'b0}};
    assign seg    = blank ? invert : (digit_pattern(digit) ^ invert);

    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.load)
        begin
            rem_next = number_value;
        end
        else if (cmd.step && !blank)
        begin
            rem_next = quot;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.step)
        begin
            out_valid_next              = 1'b1;
            out_data_next.display_index = cmd.index;
            out_data_next.segments      = seg;
            out_data_next.write_enable  = 1'b1;
            out_data_next.status        = cmd.last && (rem_next != '0);
            out_data_next.last          = cmd.last;
        end
        else if (cmd.fault)
        begin
            out_valid_next              = 1'b1;
            out_data_next.display_index = '0;
            out_data_next.segments      = '0;
            out_data_next.write_enable  = 1'b0;
            out_data_next.status        = 1'b1;
            out_data_next.last          = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

### design/dsnw_ctrl.sv
module dsnw_ctrl
    import dsnw_pkg::*;
#(
    parameter int MAX_DIGITS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [INDEX_W-1:0] digits_in_use,
    input  sts_t               sts,
    output cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [INDEX_W-1:0] cnt_reg;
    logic [INDEX_W-1:0] cnt_next;
    logic [INDEX_W-1:0] n_reg;
    logic [INDEX_W-1:0] n_next;
    logic [INDEX_W-1:0] n_sat;
    logic               accept;
    logic               at_last;

    // Clamp the display count to what the panel can hold
    assign n_sat = ({1'b0, digits_in_use} > (INDEX_W + 1)'(MAX_DIGITS))
                   ? INDEX_W'(MAX_DIGITS) : digits_in_use;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign at_last  = (cnt_reg == n_reg - INDEX_W'(1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        cmd        = '0;
        cmd.index  = cnt_reg;
        cmd.first  = (cnt_reg == '0);
        cmd.last   = at_last;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    n_next     = n_sat;
                    cnt_next   = '0;
                    state_next = (n_sat == '0) ? ST_FAULT : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + INDEX_W'(1);
                    end
                end
            end
            ST_FAULT:
            begin
                if (sts.out_free)
                begin
                    cmd.fault  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

endmodule

### design/decimal_seven_segment_number_writer.sv
// Flow: an accepted value gives one display result per cycle while the output
// is free to take it, the divide-by-ten unit producing one digit a cycle;
// a new value is not taken until the last display of the current one is issued.
// The input is taken again while the final result still waits at the output.
// Reset: common cathode, four displays, controller idle, output empty.
module decimal_seven_segment_number_writer
    import dsnw_pkg::*;
#(
    parameter int MAX_DIGITS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    dsnw_chan_if.sink   num_in,
    dsnw_chan_if.source seg_out,
    dsnw_chan_if.sink   cfg
);

    logic               common_anode_reg;
    logic [INDEX_W-1:0] digits_reg;
    cmd_t               cmd;
    sts_t               sts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_anode_reg <= 1'b0;
            digits_reg       <= DIGITS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_COMMON_ANODE:  common_anode_reg <= cfg.data.value[0];
                REG_DIGITS_IN_USE: digits_reg       <= cfg.data.value;
                default:           ;
            endcase
        end
    end

    dsnw_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (num_in.valid),
        .in_ready      (num_in.ready),
        .digits_in_use (digits_reg),
        .sts           (sts),
        .cmd           (cmd)
    );

    dsnw_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .number_value (num_in.data.number_value),
        .common_anode (common_anode_reg),
        .out_ready    (seg_out.ready),
        .out_valid    (seg_out.valid),
        .out_data     (seg_out.data)
    );

endmodule

### design/dsnw_checker.sv
module dsnw_checker
    import dsnw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_data_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Take no new value while more results of the current one are due
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input taken mid-sequence");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.last)
        else $error("status on a non-final result");

    a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |->
            out_data.last && out_data.status && (out_data.display_index == '0))
        else $error("malformed no-display result");

endmodule

bind decimal_seven_segment_number_writer dsnw_checker u_dsnw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (num_in.ready),
    .out_valid (seg_out.valid),
    .out_ready (seg_out.ready),
    .out_data  (seg_out.data)
);
